// ===== sv/xorshift64star_range_rng_macros.svh =====
// ----------------------------------------------------------------------------
// xorshift64star_range_rng assertion macros
// Shorthand for the concurrent checks in the generator.
// ----------------------------------------------------------------------------
`ifndef XORSHIFT64STAR_RANGE_RNG_MACROS_SVH
`define XORSHIFT64STAR_RANGE_RNG_MACROS_SVH

// A check that is switched off while reset is held.
`define XS_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// A check that also holds through reset.
`define XS_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== sv/xs64r_pkg.sv =====
// ----------------------------------------------------------------------------
// xs64r_pkg
// Types, constants and the state update function of the xorshift64* block.
// ----------------------------------------------------------------------------
package xs64r_pkg;

    localparam logic [63:0] SEED_DEFAULT = 64'h9E3779B97F4A7C15;
    localparam logic [63:0] MIX_MULT     = 64'h2545F4914F6CDD1D;
    localparam logic [63:0] PCT_BOUND    = 64'd100;
    localparam int          WARMUP_DRAWS = 4;
    localparam int          DIV_STEPS    = 64;

    typedef enum logic [2:0] {
        OP_RESEED = 3'd0,
        OP_BELOW  = 3'd1,
        OP_RANGE  = 3'd2,
        OP_CHANCE = 3'd3,
        OP_FRAC   = 3'd4
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WARM,
        ST_DRAW,
        ST_MUL0,
        ST_MUL1,
        ST_MUL2,
        ST_DIV,
        ST_DONE
    } t_state;

    // One xorshift step of the generator word.
    function automatic logic [63:0] xs_step(input logic [63:0] s);
        logic [63:0] x;
        x = s ^ (s >> 12);
        x = x ^ (x << 25);
        x = x ^ (x >> 27);
        return x;
    endfunction

endpackage

// ===== sv/xorshift64star_range_rng.sv =====
// ----------------------------------------------------------------------------
// xorshift64star_range_rng
// A 64-bit xorshift64* generator serving reseed, bounded, range, chance and
// fraction requests.
// ----------------------------------------------------------------------------
// Usage. A request enters on i_in_valid with i_op, i_arg_a and i_arg_b; it is
// taken at an edge where i_in_valid is high and o_in_stall is low. The block
// works on one request at a time and holds o_in_stall high until that request
// has reached the output register. Each request gives exactly one result on
// o_out_valid, taken at an edge where i_out_stall is low.
// Work per request: a draw that is reduced modulo a bound (below, range,
// chance) takes one xorshift step, three passes of a shared 32x32 multiplier
// and the 64-step restoring divider, which produces one remainder bit per
// cycle. A fraction takes the xorshift step and the three multiplier passes.
// A reseed takes four xorshift steps. Requests with nothing to draw, and
// unused op codes, go straight to the result. The next request can be taken
// in the idle state that follows the write of the previous result.
// Reset loads the default seed and runs the four warm-up steps without giving
// a result, so the block is stalled until the warm-up is through. A
// stalled result stays in the output register; the block can accept and work
// on the next request meanwhile, and that request waits before the output
// until it is free.
// ----------------------------------------------------------------------------
`include "xorshift64star_range_rng_macros.svh"

module xorshift64star_range_rng
    import xs64r_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // request channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [2:0]         i_op,
    input  logic signed [63:0] i_arg_a,
    input  logic signed [63:0] i_arg_b,
    // result channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [63:0] o_draw_value,
    output logic               o_chance_hit,
    output logic [52:0]        o_fraction,
    output logic [61:0]        o_state_view
);

    // Sequencer state and the shared step counter (warm-up and divider).
    t_state      r_state, n_state;
    logic [5:0]  r_cnt,   n_cnt;
    // Set while the warm-up that follows reset runs; that warm-up gives no result.
    logic        r_boot,  n_boot;

    // Generator word, request registers and the working registers.
    logic [63:0] r_gen,   n_gen;
    t_op         r_op,    n_op;
    logic [63:0] r_lo,    n_lo;     // range low bound, or the percent
    logic [63:0] r_div,   n_div;    // divisor of the reduction
    logic        r_use_rem, n_use_rem;
    logic [63:0] r_acc,   n_acc;    // raw product, then the dividend shifter
    logic [31:0] r_cross, n_cross;  // first cross partial product
    logic [63:0] r_rem,   n_rem;    // running remainder

    // Output register.
    logic        r_out_valid, n_out_valid;
    logic [63:0] r_out_value, n_out_value;
    logic        r_out_hit,   n_out_hit;
    logic [52:0] r_out_frac,  n_out_frac;
    logic [61:0] r_out_view,  n_out_view;

    // Decode of the incoming request.
    t_op         in_op;
    logic [63:0] span;
    logic        range_ok;
    logic        below_ok;
    logic        accept;
    logic        out_free;

    // Shared multiplier and divider step.
    logic [31:0] mul_a, mul_b;
    logic [63:0] prod;
    logic [63:0] rem_sh;
    logic        rem_ge;

    assign in_op    = t_op'(i_op);
    assign accept   = i_in_valid && (r_state == ST_IDLE);
    // The range is only drawn when lo < hi and the wrapped span stays positive.
    assign span     = 64'(i_arg_b) - 64'(i_arg_a) + 64'd1;
    assign range_ok = (i_arg_a < i_arg_b) && !span[63] && (span != 64'd0);
    assign below_ok = !i_arg_a[63] && (i_arg_a != 64'sd0);
    // The output register can take a new result when empty or being drained.
    assign out_free = !r_out_valid || !i_out_stall;

    assign prod   = 64'(mul_a) * 64'(mul_b);
    // The remainder stays below the divisor, which is below 2^63, so the
    // shifted remainder fits in 64 bits.
    assign rem_sh = {r_rem[62:0], r_acc[63]};
    assign rem_ge = (rem_sh >= r_div);

    // ------------------------------------------------------------------
    // Next state of the sequencer.
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    case (in_op)
                        OP_RESEED: n_state = ST_WARM;
                        OP_BELOW:  n_state = below_ok ? ST_DRAW : ST_DONE;
                        OP_RANGE:  n_state = range_ok ? ST_DRAW : ST_DONE;
                        OP_CHANCE: n_state = ST_DRAW;
                        OP_FRAC:   n_state = ST_DRAW;
                        default:   n_state = ST_DONE;
                    endcase
                end
            end
            ST_WARM: begin
                if (r_cnt == 6'(WARMUP_DRAWS - 1)) begin
                    n_state = r_boot ? ST_IDLE : ST_DONE;
                end
            end
            ST_DRAW: n_state = ST_MUL0;
            ST_MUL0: n_state = ST_MUL1;
            ST_MUL1: n_state = ST_MUL2;
            ST_MUL2: n_state = (r_op == OP_FRAC) ? ST_DONE : ST_DIV;
            ST_DIV: begin
                if (r_cnt == 6'(DIV_STEPS - 1)) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer outputs and datapath.
    // ------------------------------------------------------------------
    always_comb begin
        n_cnt       = r_cnt;
        n_boot      = r_boot;
        n_gen       = r_gen;
        n_op        = r_op;
        n_lo        = r_lo;
        n_div       = r_div;
        n_use_rem   = r_use_rem;
        n_acc       = r_acc;
        n_cross     = r_cross;
        n_rem       = r_rem;
        mul_a       = '0;
        mul_b       = '0;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_value = r_out_value;
        n_out_hit   = r_out_hit;
        n_out_frac  = r_out_frac;
        n_out_view  = r_out_view;
        o_in_stall  = (r_state != ST_IDLE);

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_op      = in_op;
                    n_lo      = 64'd0;
                    n_div     = PCT_BOUND;
                    n_use_rem = 1'b0;
                    n_cnt     = '0;
                    case (in_op)
                        OP_RESEED: begin
                            n_gen = (i_arg_a != 64'sd0) ? 64'(i_arg_a) : SEED_DEFAULT;
                        end
                        OP_BELOW: begin
                            n_div     = 64'(i_arg_a);
                            n_use_rem = below_ok;
                        end
                        OP_RANGE: begin
                            n_lo      = 64'(i_arg_a);
                            n_div     = span;
                            n_use_rem = range_ok;
                        end
                        OP_CHANCE: begin
                            n_lo = 64'(i_arg_a);
                        end
                        default: begin
                            n_lo = 64'd0;
                        end
                    endcase
                end
            end
            ST_WARM: begin
                n_gen = xs_step(r_gen);
                n_cnt = (r_cnt == 6'(WARMUP_DRAWS - 1)) ? 6'd0 : r_cnt + 6'd1;
                if (r_cnt == 6'(WARMUP_DRAWS - 1)) begin
                    n_boot = 1'b0;
                end
            end
            ST_DRAW: begin
                n_gen = xs_step(r_gen);
            end
            ST_MUL0: begin
                mul_a = r_gen[31:0];
                mul_b = MIX_MULT[31:0];
                n_acc = prod;
            end
            ST_MUL1: begin
                mul_a   = r_gen[31:0];
                mul_b   = MIX_MULT[63:32];
                n_cross = prod[31:0];
            end
            ST_MUL2: begin
                mul_a = r_gen[63:32];
                mul_b = MIX_MULT[31:0];
                // Only the low halves of the cross terms land below 2^64.
                n_acc = {r_acc[63:32] + r_cross + prod[31:0], r_acc[31:0]};
                n_rem = 64'd0;
                n_cnt = '0;
            end
            ST_DIV: begin
                n_rem = rem_ge ? (rem_sh - r_div) : rem_sh;
                n_acc = {r_acc[62:0], 1'b0};
                n_cnt = (r_cnt == 6'(DIV_STEPS - 1)) ? 6'd0 : r_cnt + 6'd1;
            end
            ST_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_value = 64'd0;
                    n_out_hit   = 1'b0;
                    n_out_frac  = '0;
                    n_out_view  = r_gen[61:0];
                    case (r_op)
                        OP_BELOW, OP_RANGE: begin
                            n_out_value = r_use_rem ? (r_lo + r_rem) : r_lo;
                        end
                        OP_CHANCE: begin
                            n_out_hit = !r_lo[63] && (r_rem < r_lo);
                        end
                        OP_FRAC: begin
                            n_out_frac = r_acc[63:11];
                        end
                        default: begin
                            n_out_value = 64'd0;
                        end
                    endcase
                end
            end
            default: begin
                n_cnt = '0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Registers. Reset behaves as a reseed with a zero seed.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_WARM;
            r_cnt       <= '0;
            r_boot      <= 1'b1;
            r_gen       <= SEED_DEFAULT;
            r_op        <= OP_RESEED;
            r_use_rem   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_boot      <= n_boot;
            r_gen       <= n_gen;
            r_op        <= n_op;
            r_use_rem   <= n_use_rem;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo        <= n_lo;
        r_div       <= n_div;
        r_acc       <= n_acc;
        r_cross     <= n_cross;
        r_rem       <= n_rem;
        r_out_value <= n_out_value;
        r_out_hit   <= n_out_hit;
        r_out_frac  <= n_out_frac;
        r_out_view  <= n_out_view;
    end

    assign o_out_valid  = r_out_valid;
    assign o_draw_value = signed'(r_out_value);
    assign o_chance_hit = r_out_hit;
    assign o_fraction   = r_out_frac;
    assign o_state_view = r_out_view;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    `XS_ASSERT_RST(a_gen_nonzero, r_gen != 64'd0, "generator word became zero")
    `XS_ASSERT_RST(a_rem_below_div, (r_state == ST_DIV) |-> (r_rem < r_div),
        "divider remainder not below divisor")
    `XS_ASSERT_RST(a_div_positive,
        (r_state == ST_MUL2 && r_op != OP_FRAC) |=> (r_div != 64'd0 && !r_div[63]),
        "reduction started with a divisor that is not positive")
    `XS_ASSERT_RST(a_cnt_idle,
        (r_state != ST_WARM && r_state != ST_DIV) |-> (r_cnt == 6'd0),
        "step counter not cleared outside warm-up and division")
    `XS_ASSERT_ALWAYS(a_reset_stalls, !i_rst_n |=> o_in_stall,
        "request accepted straight after reset")

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the xorshift64* generator: a table of directed
// requests followed by random traffic, each result checked field by field
// against an in-bench model of the generator word.
// ----------------------------------------------------------------------------
module testbench;
    import xs64r_pkg::*;

    // Op codes the block accepts but ignores.
    localparam logic [2:0] OP_SPARE_5 = 3'd5;
    localparam logic [2:0] OP_SPARE_6 = 3'd6;
    localparam logic [2:0] OP_SPARE_7 = 3'd7;

    localparam logic [63:0] S64_MIN  = 64'h8000_0000_0000_0000;
    localparam logic [63:0] S64_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

    localparam int DIRECTED_COUNT = 25;
    localparam int RANDOM_COUNT   = 900;
    localparam int IDLE_PERCENT   = 15;
    // Random requests in this window are offered with no idle gaps, and their results are not refused.
    localparam int QUIET_FIRST    = 400;
    localparam int QUIET_LAST     = 549;
    // The sender waits for the block to drain at this random request.
    localparam int DRAIN_AT       = 300;
    // The receiver refuses results for a long stretch after this many.
    localparam int HOLD_AT        = 120;
    localparam int HOLD_CYCLES    = 300;
    // Idle margin at the end of the run, after the last result has drained.
    localparam int TAIL_CYCLES    = 80;
    localparam int CYCLE_LIMIT    = 600_000;

    // One row of stimulus. Where typed is set, draw_value and chance_hit
    // are taken from the row rather than from the model.
    typedef struct packed {
        logic [2:0]  op;
        logic [63:0] arg_a;
        logic [63:0] arg_b;
        logic        typed;
        logic [63:0] want_value;
        logic        want_hit;
    } t_request_row;

    typedef struct packed {
        logic [63:0] draw_value;
        logic        chance_hit;
        logic [52:0] fraction;
        logic [61:0] state_view;
    } t_draw_result;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    logic               o_in_stall;
    logic [2:0]         i_op        = OP_RESEED;
    logic signed [63:0] i_arg_a     = '0;
    logic signed [63:0] i_arg_b     = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic signed [63:0] o_draw_value;
    logic               o_chance_hit;
    logic [52:0]        o_fraction;
    logic [61:0]        o_state_view;

    // Model of the generator word, advanced as each request is accepted.
    logic [63:0]  gen_word;
    t_draw_result pending_draws[$];
    int           error_total = 0;
    int           cycle_count = 0;
    bit           quiet_window = 1'b0;

    // The directed table. Rows with typed clear are left to the model:
    // anything that depends on an actual draw cannot be read off by eye.
    t_request_row directed_rows [DIRECTED_COUNT] = '{
        // below: a bound of zero or any negative bound draws nothing
        '{OP_BELOW,   64'd0,        64'd0,        1'b1, 64'd0,  1'b0},
        '{OP_BELOW,   ALL_ONES,     64'd0,        1'b1, 64'd0,  1'b0},
        '{OP_BELOW,   S64_MIN,      ALL_ONES,     1'b1, 64'd0,  1'b0},
        // below one always gives zero, but the draw still happens
        '{OP_BELOW,   64'd1,        64'd0,        1'b1, 64'd0,  1'b0},
        '{OP_BELOW,   S64_MAX,      S64_MIN,      1'b0, 64'd0,  1'b0},
        '{OP_BELOW,   64'd12345,    64'd0,        1'b0, 64'd0,  1'b0},
        // range: an empty or reversed span returns the low bound
        '{OP_RANGE,   64'd5,        64'd5,        1'b1, 64'd5,  1'b0},
        '{OP_RANGE,   64'd10,       -64'sd3,      1'b1, 64'd10, 1'b0},
        // range: spans that wrap to zero or to a negative value
        '{OP_RANGE,   S64_MIN,      S64_MAX,      1'b1, S64_MIN, 1'b0},
        '{OP_RANGE,   ALL_ONES,     S64_MAX,      1'b1, ALL_ONES, 1'b0},
        '{OP_RANGE,   -64'sd10,     64'd10,       1'b0, 64'd0,  1'b0},
        '{OP_RANGE,   S64_MAX - 1,  S64_MAX,      1'b0, 64'd0,  1'b0},
        '{OP_RANGE,   S64_MIN,      S64_MIN + 1,  1'b0, 64'd0,  1'b0},
        // chance: zero or a negative percent never hits, a hundred or more always hits
        '{OP_CHANCE,  64'd0,        64'd0,        1'b1, 64'd0,  1'b0},
        '{OP_CHANCE,  64'd100,      64'd0,        1'b1, 64'd0,  1'b1},
        '{OP_CHANCE,  ALL_ONES,     64'd0,        1'b1, 64'd0,  1'b0},
        '{OP_CHANCE,  S64_MAX,      64'd0,        1'b1, 64'd0,  1'b1},
        '{OP_CHANCE,  64'd50,       64'd0,        1'b0, 64'd0,  1'b0},
        '{OP_FRAC,    64'd0,        64'd0,        1'b0, 64'd0,  1'b0},
        // reseed: a zero seed falls back to the default constant
        '{OP_RESEED,  64'd0,        64'd0,        1'b0, 64'd0,  1'b0},
        '{OP_RESEED,  ALL_ONES,     64'd0,        1'b0, 64'd0,  1'b0},
        '{OP_RESEED,  S64_MIN,      64'd0,        1'b0, 64'd0,  1'b0},
        // spare op codes leave the state alone and give an empty result
        '{OP_SPARE_5, 64'h1234,     64'h5678,     1'b1, 64'd0,  1'b0},
        '{OP_SPARE_6, ALL_ONES,     ALL_ONES,     1'b1, 64'd0,  1'b0},
        '{OP_SPARE_7, S64_MIN,      S64_MAX,      1'b1, 64'd0,  1'b0}
    };

    xorshift64star_range_rng u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_op         (i_op),
        .i_arg_a      (i_arg_a),
        .i_arg_b      (i_arg_b),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_draw_value (o_draw_value),
        .o_chance_hit (o_chance_hit),
        .o_fraction   (o_fraction),
        .o_state_view (o_state_view)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Generator model
    // ------------------------------------------------------------------------

    // Three xorshift passes on the model word, then the output multiply.
    function automatic logic [63:0] scrambled_draw();
        logic [63:0] x;
        x = gen_word;
        x = x ^ (x >> 12);
        x = x ^ (x << 25);
        x = x ^ (x >> 27);
        gen_word = x;
        return x * MIX_MULT;
    endfunction

    function automatic void load_seed(input logic [63:0] seed);
        gen_word = (seed != 64'd0) ? seed : SEED_DEFAULT;
        for (int i = 0; i < WARMUP_DRAWS; i++)
            void'(scrambled_draw());
    endfunction

    // A draw reduced below n. A bound that is zero or negative as a signed
    // value gives zero and leaves the word untouched.
    function automatic logic [63:0] draw_below(input logic [63:0] n);
        if (n == 64'd0 || n[63])
            return 64'd0;
        return scrambled_draw() % n;
    endfunction

    function automatic t_draw_result model_request(input logic [2:0] op,
                                                   input logic [63:0] a,
                                                   input logic [63:0] b);
        t_draw_result r;
        logic [63:0]  pct_draw;
        logic [63:0]  raw;
        r = '0;
        case (op)
            OP_RESEED: load_seed(a);
            OP_BELOW:  r.draw_value = draw_below(a);
            OP_RANGE: begin
                // The span is taken modulo 2^64; draw_below rejects it when
                // it wraps to zero or past the sign bit.
                if ($signed(a) < $signed(b))
                    r.draw_value = a + draw_below(b - a + 64'd1);
                else
                    r.draw_value = a;
            end
            OP_CHANCE: begin
                pct_draw     = draw_below(PCT_BOUND);
                r.chance_hit = !a[63] && (pct_draw < a);
            end
            OP_FRAC: begin
                raw        = scrambled_draw();
                r.fraction = raw[63:11];
            end
            default: ;
        endcase
        r.state_view = gen_word[61:0];
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Random requests
    // ------------------------------------------------------------------------

    function automatic logic [63:0] any_word();
        return {$urandom, $urandom};
    endfunction

    // Mostly well-formed bounds in useful ranges, with a share of raw noise,
    // degenerate bounds and the occasional spare op code.
    function automatic t_request_row random_request();
        t_request_row row;
        int           pick;
        int           shape;
        longint       lo;
        row       = '0;
        row.arg_a = any_word();
        row.arg_b = any_word();
        pick      = $urandom_range(99);
        shape     = $urandom_range(99);
        if (pick < 5) begin
            row.op = OP_RESEED;
            if (shape < 20)
                row.arg_a = 64'd0;
        end else if (pick < 8) begin
            case ($urandom_range(2))
                0:       row.op = OP_SPARE_5;
                1:       row.op = OP_SPARE_6;
                default: row.op = OP_SPARE_7;
            endcase
        end else if (pick < 31) begin
            row.op = OP_BELOW;
            if (shape < 60)
                row.arg_a = 64'($urandom_range(1000, 1));
            else if (shape < 75)
                row.arg_a = row.arg_a & S64_MAX;
            else if (shape < 85)
                row.arg_a = -64'($urandom_range(5));
        end else if (pick < 56) begin
            row.op = OP_RANGE;
            lo     = longint'($urandom_range(2000)) - 1000;
            if (shape < 50) begin
                row.arg_a = lo;
                row.arg_b = lo + longint'($urandom_range(2000));
            end else if (shape < 65) begin
                row.arg_a = lo;
                row.arg_b = lo - longint'($urandom_range(50));
            end else if (shape < 75) begin
                row.arg_a = S64_MAX - 64'($urandom_range(100));
                row.arg_b = S64_MAX;
            end else if (shape < 80) begin
                row.arg_a = S64_MIN;
                row.arg_b = S64_MIN + 64'($urandom_range(100));
            end
        end else if (pick < 80) begin
            row.op = OP_CHANCE;
            if (shape < 80)
                row.arg_a = longint'($urandom_range(110)) - 5;
        end else begin
            row.op = OP_FRAC;
        end
        return row;
    endfunction

    // ------------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------------

    // Offers one request and returns once it has been taken. The expected
    // result is worked out at the edge of acceptance, so the model keeps
    // step with the block's own order.
    task automatic offer_request(input t_request_row row);
        t_draw_result want;
        if (!quiet_window) begin
            while ($urandom_range(99) < IDLE_PERCENT) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_in_valid <= 1'b1;
        i_op       <= row.op;
        i_arg_a    <= row.arg_a;
        i_arg_b    <= row.arg_b;
        do
            @(posedge i_clk);
        while (o_in_stall);
        want = model_request(row.op, row.arg_a, row.arg_b);
        if (row.typed) begin
            want.draw_value = row.want_value;
            want.chance_hit = row.want_hit;
            want.fraction   = '0;
        end
        pending_draws.push_back(want);
    endtask

    // Lowers valid and waits until every outstanding result has come back.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        do
            @(posedge i_clk);
        while (pending_draws.size() != 0);
    endtask

    initial begin : request_side
        t_request_row row;
        // The block comes out of reset as if reseeded with zero.
        load_seed(64'd0);
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < DIRECTED_COUNT; i++)
            offer_request(directed_rows[i]);
        drain_results();

        for (int i = 0; i < RANDOM_COUNT; i++) begin
            if (i == DRAIN_AT)
                drain_results();
            quiet_window = (i >= QUIET_FIRST && i <= QUIET_LAST);
            row = random_request();
            offer_request(row);
        end
        quiet_window = 1'b0;
        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (error_total == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------------

    task automatic check_result();
        t_draw_result want;
        if (pending_draws.size() == 0) begin
            $error("result with no request outstanding");
            error_total++;
            return;
        end
        want = pending_draws.pop_front();
        if (o_draw_value !== want.draw_value) begin
            $error("draw_value: expected %h, got %h", want.draw_value, o_draw_value);
            error_total++;
        end
        if (o_chance_hit !== want.chance_hit) begin
            $error("chance_hit: expected %b, got %b", want.chance_hit, o_chance_hit);
            error_total++;
        end
        if (o_fraction !== want.fraction) begin
            $error("fraction: expected %h, got %h", want.fraction, o_fraction);
            error_total++;
        end
        if (o_state_view !== want.state_view) begin
            $error("state_view: expected %h, got %h", want.state_view, o_state_view);
            error_total++;
        end
    endtask

    // Results are sampled just after the edge, so the values seen are those
    // the edge itself acted on. The stall for the next edge is driven once
    // per edge. After HOLD_AT results the receiver refuses everything for a
    // long stretch while requests keep coming, so that the block backs up.
    initial begin : result_side
        int taken;
        int hold_left;
        bit held;
        taken     = 0;
        hold_left = 0;
        held      = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            @(posedge i_clk);
            if (o_out_valid && !i_out_stall) begin
                check_result();
                taken++;
            end
            if (taken == HOLD_AT && !held) begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (quiet_window) begin
                i_out_stall <= 1'b0;
            end else begin
                i_out_stall <= ($urandom_range(99) < IDLE_PERCENT);
            end
        end
    end

    // Run guard: a hang anywhere ends the run as a failure.
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("FAILURE");
        $finish;
    end

endmodule
